// ===== rtl/ghl_pkg.sv =====
// Package for the grid histogram localiser: shared widths, codes, word types and
// the control/status structs. It depends on nothing.
package ghl_pkg;

    localparam int ROWS      = 8;
    localparam int COLS      = 8;
    localparam int CELLS     = ROWS * COLS;
    localparam int ROW_W     = 3;
    localparam int COL_W     = 3;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int BELIEF_W  = 16;
    localparam int PROD_W    = 32;
    localparam int SUM_W     = PROD_W + ADDR_W;
    localparam int QUOT_W    = 17;
    localparam int DIVIDEND_W = PROD_W + 16;

    localparam int UNIFORM_RAW = 65536 / CELLS;
    localparam logic [BELIEF_W-1:0] UNIFORM_BELIEF =
        (UNIFORM_RAW > 65535) ? 16'hFFFF : BELIEF_W'(UNIFORM_RAW);

    localparam logic [15:0] HIT_RESET  = 16'd768;
    localparam logic [15:0] MISS_RESET = 16'd256;

    // Register indexes of the configuration port.
    localparam logic CFG_HIT  = 1'b0;
    localparam logic CFG_MISS = 1'b1;

    // Operation codes.
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_INIT  = 2'd1;
    localparam logic [1:0] OP_SENSE = 2'd2;
    localparam logic [1:0] OP_MOVE  = 2'd3;

    typedef struct packed {
        logic [1:0]       operation;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [7:0]       color;
        logic signed [3:0] shift_rows;
        logic signed [3:0] shift_cols;
    } t_in_word;

    typedef struct packed {
        logic [15:0] belief;
        logic        status;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              capture;    // latch the input word
        logic              load_map;   // write the colour map
        logic              init_all;   // mark every belief uniform
        logic              clr_sum;    // clear accumulator
        logic              prod_wr;    // write product and accumulate
        logic              div_start;  // start division for sweep index
        logic              div_wr;     // write quotient to belief
        logic              mv_wr;      // write to scratch at shifted place
        logic              cp_wr;      // write scratch to belief
        logic              rd_out;     // read belief at (row,col)
        logic              out_load;   // load the output register
        logic [ADDR_W-1:0] idx;        // sweep index
    } t_cmd;

    typedef struct packed {
        logic       div_done;
        logic       sum_zero;
        logic [1:0] operation;
    } t_stat;

endpackage

// ===== rtl/ghl_divider.sv =====
// Restoring divider for the sense normalisation: one quotient bit a cycle.
// Depends on ghl_pkg.
module ghl_divider (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ghl_pkg::PROD_W-1:0]   i_num,
    input  logic [ghl_pkg::SUM_W-1:0]    i_den,
    output logic                         o_done,
    output logic [ghl_pkg::BELIEF_W-1:0] o_quot
);
    import ghl_pkg::*;

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] r_num, n_num;
    logic [SUM_W:0]        r_rem, n_rem;
    logic [QUOT_W-1:0]     r_quot, n_quot;
    logic [SUM_W-1:0]      r_den;
    logic [STEP_W-1:0]     r_step, n_step;
    logic                  r_busy, n_busy, r_done, n_done, r_big, n_big;
    logic [SUM_W:0]        w_trial;

    // One shift-subtract step per cycle.
    always_comb begin
        n_num  = r_num;
        n_rem  = r_rem;
        n_quot = r_quot;
        n_step = r_step;
        n_busy = r_busy;
        n_done = 1'b0;
        n_big  = r_big;
        w_trial = {r_rem[SUM_W-1:0], r_num[DIVIDEND_W-1]};
        if (i_start) begin
            n_num  = {i_num, 16'd0};
            n_rem  = '0;
            n_quot = '0;
            n_step = '0;
            n_busy = 1'b1;
            n_big  = 1'b0;
        end else if (r_busy) begin
            n_num = {r_num[DIVIDEND_W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = w_trial - {1'b0, r_den};
                n_quot = {r_quot[QUOT_W-2:0], 1'b1};
                if (r_quot[QUOT_W-1]) n_big = 1'b1;
            end else begin
                n_rem = w_trial;
                n_quot = {r_quot[QUOT_W-2:0], 1'b0};
                if (r_quot[QUOT_W-1]) n_big = 1'b1;
            end
            n_step = r_step + 1'b1;
            if (r_step == STEP_W'(DIVIDEND_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_num  <= n_num;
        r_rem  <= n_rem;
        r_quot <= n_quot;
        r_step <= n_step;
        r_big  <= n_big;
        if (i_start) r_den <= i_den;
    end

    assign o_done = r_done;
    assign o_quot = (r_big || r_quot[QUOT_W-1]) ? 16'hFFFF : r_quot[BELIEF_W-1:0];
endmodule

// ===== rtl/ghl_datapath.sv =====
// Datapath of the localiser: colour map, belief and scratch memories, the
// product accumulator, the divider and the output register. Depends on ghl_pkg.
module ghl_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ghl_pkg::t_cmd      i_cmd,
    output ghl_pkg::t_stat     o_stat,
    input  ghl_pkg::t_in_word  i_word,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    output ghl_pkg::t_out_word o_word
);
    import ghl_pkg::*;

    t_in_word            r_word;
    logic [15:0]         r_hit, r_miss;
    logic [7:0]          color_mem [CELLS];
    logic [BELIEF_W-1:0] belief_mem [CELLS];
    logic [PROD_W-1:0]   scratch_mem [CELLS];
    logic [CELLS-1:0]    r_uni;
    logic [ADDR_W-1:0]   r_idx;
    logic [BELIEF_W-1:0] r_bel_rd;
    logic [7:0]          r_col_rd;
    logic [PROD_W-1:0]   r_scr_rd;
    logic [SUM_W-1:0]    r_sum;
    logic [PROD_W-1:0]   r_prod;
    logic [15:0]         w_weight;
    logic [BELIEF_W-1:0] w_bel;
    logic [BELIEF_W-1:0] w_quot;
    logic                w_done;
    logic [ROW_W-1:0]    w_sy, w_ni;
    logic [COL_W-1:0]    w_sx, w_nj;
    logic [ADDR_W-1:0]   w_mv_addr, w_out_addr;
    logic [ADDR_W-1:0]   w_rd_addr;
    t_out_word           r_out;

    // Shift amounts wrap modulo the grid size (power of two).
    assign w_sy = r_word.shift_rows[ROW_W-1:0];
    assign w_sx = r_word.shift_cols[COL_W-1:0];
    assign w_ni = r_idx[ADDR_W-1:COL_W] + w_sy;
    assign w_nj = r_idx[COL_W-1:0] + w_sx;
    assign w_mv_addr  = {w_ni, w_nj};
    assign w_out_addr = {r_word.row, r_word.col};
    assign w_rd_addr  = i_cmd.rd_out ? w_out_addr : i_cmd.idx;

    // Unwritten cells read as the uniform value.
    assign w_bel    = r_uni[r_idx] ? UNIFORM_BELIEF : r_bel_rd;
    assign w_weight = (r_col_rd == r_word.color) ? r_hit : r_miss;

    always_ff @(posedge i_clk) begin
        r_prod <= w_bel * w_weight;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit  <= HIT_RESET;
            r_miss <= MISS_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_HIT) r_hit <= i_cfg_data;
            else r_miss <= i_cfg_data;
        end
    end

    // Memories with registered reads.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_word <= i_word;
        if (i_cmd.load_map) color_mem[w_out_addr] <= r_word.color;
        r_bel_rd <= belief_mem[w_rd_addr];
        r_col_rd <= color_mem[i_cmd.idx];
        r_scr_rd <= scratch_mem[i_cmd.idx];
        r_idx    <= w_rd_addr;
        if (i_cmd.prod_wr) scratch_mem[i_cmd.idx] <= r_prod;
        if (i_cmd.mv_wr)   scratch_mem[w_mv_addr] <= {16'd0, w_bel};
        if (i_cmd.div_wr)  belief_mem[i_cmd.idx] <= w_quot;
        if (i_cmd.cp_wr)   belief_mem[i_cmd.idx] <= r_scr_rd[BELIEF_W-1:0];
    end

    // Uniform flags stand in for a clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.init_all) begin
            r_uni <= '1;
        end else if (i_cmd.div_wr || i_cmd.cp_wr) begin
            r_uni[i_cmd.idx] <= 1'b0;
        end
    end

    // Product sum accumulator.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_sum) r_sum <= '0;
        else if (i_cmd.prod_wr) r_sum <= r_sum + SUM_W'(r_prod);
    end

    ghl_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (r_scr_rd),
        .i_den  (r_sum),
        .o_done (w_done),
        .o_quot (w_quot)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.belief <= w_bel;
            r_out.status <= (r_word.operation == OP_SENSE) && (r_sum == '0);
        end
    end

    assign o_stat.div_done  = w_done;
    assign o_stat.sum_zero  = (r_sum == '0);
    assign o_stat.operation = r_word.operation;
    assign o_word           = r_out;
endmodule

// ===== rtl/ghl_ctrl.sv =====
// Controller of the localiser: sequences each operation, sweeping the grid for sense
// and move, and runs the handshakes. Depends on ghl_pkg.
module ghl_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output ghl_pkg::t_cmd  o_cmd,
    input  ghl_pkg::t_stat i_stat
);
    import ghl_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_PRD   = 4'd2;
    localparam logic [3:0] S_PMUL  = 4'd3;
    localparam logic [3:0] S_PWR   = 4'd4;
    localparam logic [3:0] S_DRD   = 4'd5;
    localparam logic [3:0] S_DST   = 4'd6;
    localparam logic [3:0] S_DWT   = 4'd7;
    localparam logic [3:0] S_MRD   = 4'd8;
    localparam logic [3:0] S_MWR   = 4'd9;
    localparam logic [3:0] S_CRD   = 4'd10;
    localparam logic [3:0] S_CWR   = 4'd11;
    localparam logic [3:0] S_ORD   = 4'd12;
    localparam logic [3:0] S_OLD   = 4'd13;

    logic [3:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic              r_ovalid, n_ovalid;
    logic              w_last;

    assign w_last = (r_idx == ADDR_W'(CELLS - 1));

    // Next state and commands.
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_ovalid = r_ovalid;
        o_cmd    = '0;
        o_cmd.idx = r_idx;
        if (r_ovalid && i_out_ready) n_ovalid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_idx = '0;
                o_cmd.clr_sum = 1'b1;
                unique case (i_stat.operation)
                    OP_LOAD: begin
                        o_cmd.load_map = 1'b1;
                        n_state = S_ORD;
                    end
                    OP_INIT: begin
                        o_cmd.init_all = 1'b1;
                        n_state = S_ORD;
                    end
                    OP_SENSE: n_state = S_PRD;
                    default:  n_state = S_MRD;
                endcase
            end
            S_PRD:  n_state = S_PMUL;
            S_PMUL: n_state = S_PWR;
            S_PWR: begin
                o_cmd.prod_wr = 1'b1;
                n_idx = r_idx + 1'b1;
                n_state = w_last ? S_DRD : S_PRD;
            end
            S_DRD: begin
                n_state = i_stat.sum_zero ? S_ORD : S_DST;
            end
            S_DST: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DWT;
            end
            S_DWT: begin
                if (i_stat.div_done) begin
                    o_cmd.div_wr = 1'b1;
                    n_idx = r_idx + 1'b1;
                    n_state = w_last ? S_ORD : S_DRD;
                end
            end
            S_MRD: n_state = S_MWR;
            S_MWR: begin
                o_cmd.mv_wr = 1'b1;
                n_idx = r_idx + 1'b1;
                n_state = w_last ? S_CRD : S_MRD;
            end
            S_CRD: n_state = S_CWR;
            S_CWR: begin
                o_cmd.cp_wr = 1'b1;
                n_idx = r_idx + 1'b1;
                n_state = w_last ? S_ORD : S_CRD;
            end
            S_ORD: begin
                o_cmd.rd_out = 1'b1;
                n_state = S_OLD;
            end
            S_OLD: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
endmodule

// ===== rtl/grid_histogram_localizer_unit.sv =====
// A discrete Bayes histogram filter over an 8 by 8 cyclic grid. Sense forms and
// sums the products over the grid and then normalises each cell with the
// bit-serial divider, which produces one quotient bit a cycle; move copies belief
// to scratch and back as a single-port sweep. The result register lets the next
// word be accepted while a result waits. Depends on ghl_pkg, ghl_ctrl and
// ghl_datapath.
module grid_histogram_localizer_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ghl_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ghl_pkg::t_out_word o_out_data,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);
    import ghl_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    ghl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    ghl_datapath u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_stat    (w_stat),
        .i_word    (i_in_data),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .o_word    (o_out_data)
    );
endmodule

// ===== rtl/ghl_checker.sv =====
// Port-level checker for the localiser, bound to the top level.
// Depends on ghl_pkg.
module ghl_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input ghl_pkg::t_out_word o_out_data
);
    import ghl_pkg::*;

    // A result stays put until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result word changed while stalled");

    // Ready is low in the very next cycle after a word is accepted.
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready held after acceptance");

    // A result word that is offered is always fully known.
    a_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !$isunknown(o_out_data))
        else $error("unknown bits in result word");

    // No result comes out of reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !o_out_valid)
        else $error("result word after reset");
endmodule

bind grid_histogram_localizer_unit ghl_checker u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);

// ===== test/grid_histogram_localizer_unit_tb.sv =====
// Self-checking testbench for grid_histogram_localizer_unit: directed table plus random words,
// each result checked against a typed table value or a behavioural belief-grid model held here.
// Depends on ghl_pkg and the RTL of grid_histogram_localizer_unit.
`timescale 1ns / 1ps

module grid_histogram_localizer_unit_tb;
    import ghl_pkg::*;

    localparam int STALL_LIMIT = 40000;

    typedef struct {
        bit          is_cfg;
        logic [15:0] hit;
        logic [15:0] miss;
        t_in_word    word;
        bit          typed;
        t_out_word   exp;
    } t_row;

    typedef struct {
        bit        typed;
        t_out_word exp;
    } t_typed;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_word    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_word   o_out_data;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = CFG_HIT;
    logic [15:0] i_cfg_data = '0;

    // Model state of the belief grid.
    logic [15:0] belief_grid [CELLS];
    logic [7:0]  colour_grid [CELLS];
    logic [15:0] hit_w;
    logic [15:0] miss_w;

    t_out_word   pending_beliefs [$];
    t_typed      typed_queue [$];
    int          mismatches = 0;
    int          quiet_cycles = 0;
    bit          calm = 1'b0;
    t_row        rows [$];

    grid_histogram_localizer_unit dut (.*);

    always #5 i_clk = ~i_clk;

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Applies one word to the model grid and returns the belief read back.
    function automatic t_out_word localise(input t_in_word w);
        t_out_word   r;
        logic [31:0] prod [CELLS];
        logic [63:0] total;
        logic [63:0] q;
        logic [15:0] moved [CELLS];
        int          k;
        r.status = 1'b0;
        case (w.operation)
            OP_LOAD: colour_grid[{w.row, w.col}] = w.color;
            OP_INIT: for (k = 0; k < CELLS; k++) belief_grid[k] = UNIFORM_BELIEF;
            OP_SENSE: begin
                total = '0;
                for (k = 0; k < CELLS; k++) begin
                    prod[k] = belief_grid[k] * ((colour_grid[k] == w.color) ? hit_w : miss_w);
                    total += prod[k];
                end
                if (total == 0) begin
                    r.status = 1'b1;
                end else begin
                    for (k = 0; k < CELLS; k++) begin
                        q = {prod[k], 16'h0000} / total;
                        belief_grid[k] = (q > 65535) ? 16'hFFFF : q[15:0];
                    end
                end
            end
            default: begin
                // A true modulo of a 4-bit shift by 8 is its low three bits.
                for (k = 0; k < CELLS; k++)
                    moved[{3'(k / COLS + w.shift_rows[2:0]), 3'(k % COLS + w.shift_cols[2:0])}]
                        = belief_grid[k];
                belief_grid = moved;
            end
        endcase
        r.belief = belief_grid[{w.row, w.col}];
        return r;
    endfunction

    // Input side: predict at each accepted word.
    always @(posedge i_clk) begin
        t_typed    t;
        t_out_word p;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            t = typed_queue.pop_front();
            p = localise(i_in_data);
            pending_beliefs.push_back(t.typed ? t.exp : p);
        end
    end

    // Output side: compare each result with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_beliefs.size() == 0) begin
                report("result with nothing expected");
            end else begin
                e = pending_beliefs.pop_front();
                if (o_out_data.belief !== e.belief)
                    report($sformatf("belief %0d, expected %0d", o_out_data.belief, e.belief));
                if (o_out_data.status !== e.status)
                    report($sformatf("status %0b, expected %0b", o_out_data.status, e.status));
            end
        end
    end

    // Receiver stalls at random outside the calm stretch.
    always @(posedge i_clk)
        i_out_ready <= calm || ($urandom_range(99) >= 29);

    // Watchdog on cycles with no word moving either way.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send(input t_in_word w, input bit typed, input t_out_word exp);
        t_typed t;
        if (!calm && $urandom_range(99) < 29) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        t.typed = typed;
        t.exp   = exp;
        typed_queue.push_back(t);
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_beliefs.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Weights change only with the block idle.
    task automatic set_weights(input logic [15:0] hit, input logic [15:0] miss);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_HIT;
        i_cfg_data <= hit;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MISS;
        i_cfg_data <= miss;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        hit_w  = hit;
        miss_w = miss;
    endtask

    function automatic t_in_word word_of(input logic [1:0] op, input logic [2:0] r,
                                         input logic [2:0] c, input logic [7:0] colour,
                                         input logic [3:0] sr, input logic [3:0] sc);
        t_in_word w;
        w.operation  = op;
        w.row        = r;
        w.col        = c;
        w.color      = colour;
        w.shift_rows = sr;
        w.shift_cols = sc;
        return w;
    endfunction

    function automatic logic [7:0] pick_colour();
        return ($urandom_range(99) < 80) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
    endfunction

    task automatic add(input t_in_word w, input bit typed, input logic [15:0] b,
                       input logic s);
        t_row r;
        r.is_cfg = 1'b0;
        r.word   = w;
        r.typed  = typed;
        r.exp    = '{belief: b, status: s};
        rows.push_back(r);
    endtask

    task automatic add_cfg(input logic [15:0] hit, input logic [15:0] miss);
        t_row r;
        r.is_cfg = 1'b1;
        r.hit    = hit;
        r.miss   = miss;
        rows.push_back(r);
    endtask

    initial begin
        t_in_word    w;
        int          k;
        int          ph;
        int          n;
        logic [15:0] hits [6]   = '{16'd768, 16'hFFFF, 16'd1, 16'd0, 16'd256, 16'hFFFF};
        logic [15:0] misses [6] = '{16'd256, 16'd1, 16'hFFFF, 16'd300, 16'd256, 16'hFFFF};

        for (k = 0; k < CELLS; k++) belief_grid[k] = UNIFORM_BELIEF;
        hit_w  = HIT_RESET;
        miss_w = MISS_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the whole colour map first, so no sense reads an unwritten cell.
        for (k = 0; k < CELLS; k++)
            send(word_of(OP_LOAD, 3'(k / COLS), 3'(k % COLS), 8'(k % 4), 4'd0, 4'd0),
                 1'b0, '0);

        // Directed table: extreme shifts, saturation, zero product sums.
        add(word_of(OP_INIT, 3'd0, 3'd0, 8'd0, 4'd0, 4'd0), 1'b1, 16'd1024, 1'b0);
        add(word_of(OP_MOVE, 3'd7, 3'd7, 8'd0, 4'd7, 4'd7), 1'b0, 16'd0, 1'b0);
        add(word_of(OP_MOVE, 3'd1, 3'd6, 8'd0, 4'b1000, 4'b1000), 1'b0, 16'd0, 1'b0);
        add(word_of(OP_LOAD, 3'd7, 3'd7, 8'd255, 4'd0, 4'd0), 1'b1, 16'd1024, 1'b0);
        add(word_of(OP_SENSE, 3'd7, 3'd7, 8'd255, 4'd0, 4'd0), 1'b0, 16'd0, 1'b0);
        add(word_of(OP_MOVE, 3'd0, 3'd0, 8'd0, 4'b1001, 4'b1111), 1'b0, 16'd0, 1'b0);
        add(word_of(OP_SENSE, 3'd2, 3'd5, 8'd1, 4'd0, 4'd0), 1'b0, 16'd0, 1'b0);
        add(word_of(OP_INIT, 3'd7, 3'd7, 8'd0, 4'd0, 4'd0), 1'b1, 16'd1024, 1'b0);
        add_cfg(16'd0, 16'd0);
        add(word_of(OP_SENSE, 3'd3, 3'd3, 8'd3, 4'd0, 4'd0), 1'b1, 16'd1024, 1'b1);
        add_cfg(16'hFFFF, 16'd0);
        add(word_of(OP_SENSE, 3'd4, 3'd1, 8'd200, 4'd0, 4'd0), 1'b1, 16'd1024, 1'b1);
        add(word_of(OP_SENSE, 3'd7, 3'd7, 8'd255, 4'd0, 4'd0), 1'b1, 16'hFFFF, 1'b0);
        add(word_of(OP_SENSE, 3'd0, 3'd0, 8'd255, 4'd0, 4'd0), 1'b1, 16'd0, 1'b0);
        add(word_of(OP_MOVE, 3'd0, 3'd0, 8'd0, 4'd1, 4'd1), 1'b1, 16'hFFFF, 1'b0);
        add_cfg(16'hFFFF, 16'hFFFF);
        add(word_of(OP_INIT, 3'd5, 3'd2, 8'd0, 4'd0, 4'd0), 1'b1, 16'd1024, 1'b0);
        add(word_of(OP_SENSE, 3'd5, 3'd2, 8'd2, 4'd0, 4'd0), 1'b0, 16'd0, 1'b0);
        add(word_of(OP_SENSE, 3'd6, 3'd6, 8'd0, 4'd0, 4'd0), 1'b0, 16'd0, 1'b0);

        foreach (rows[i]) begin
            if (rows[i].is_cfg)
                set_weights(rows[i].hit, rows[i].miss);
            else
                send(rows[i].word, rows[i].typed, rows[i].exp);
        end

        // Random phases, one weight setting each; the second runs without stalls.
        for (ph = 0; ph < 6; ph++) begin
            set_weights(hits[ph], misses[ph]);
            calm = (ph == 1);
            for (n = 0; n < 62; n++) begin
                k = $urandom_range(99);
                w = word_of(OP_MOVE, 3'($urandom_range(7)), 3'($urandom_range(7)),
                            pick_colour(), 4'($urandom_range(15)), 4'($urandom_range(15)));
                if (k < 30)
                    w.operation = OP_LOAD;
                else if (k < 38)
                    w.operation = OP_INIT;
                else if (k < 62)
                    w.operation = OP_SENSE;
                send(w, 1'b0, '0);
            end
            calm = 1'b0;
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_beliefs.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
